FILE: design/frame_table_aging_replacement_top_assert.svh
// Assertion macros shared by the checker of the frame table.
`ifndef FRAME_TABLE_AGING_REPLACEMENT_TOP_ASSERT_SVH
`define FRAME_TABLE_AGING_REPLACEMENT_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define FTAR_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame table check failed");

// Condition that must never be seen outside reset.
`define FTAR_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("frame table forbidden condition seen");

`endif

FILE: design/ftar_pkg.sv
// ----------------------------------------------------------------------------
// ftar_pkg
// Shared constants, codes and controller/datapath types of the frame table.
// ----------------------------------------------------------------------------
package ftar_pkg;

  localparam int FRAMES_DEF      = 64;
  localparam int RECENT_BITS_DEF = 8;
  localparam int PAGE_BITS_DEF   = 20;
  localparam int OWNER_BITS_DEF  = 8;

  localparam int OP_W     = 3;
  localparam int IDX_W_IO = 6;
  localparam int PAGE_W_IO = 20;
  localparam int OWNER_W_IO = 8;
  localparam int RECENT_W_IO = 8;
  localparam int BITS_W_IO = 64;
  localparam int OCC_W_IO  = 7;
  localparam int STATUS_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_AGE    = 3'd3;
  localparam logic [OP_W-1:0] OP_EVICT  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_READ, S_SCAN, S_DRAIN, S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {K_NONE, K_READ, K_SWEEP} kind_t;

  typedef struct packed {
    logic capture;
    logic dispatch;
    logic rd;
    logic rd_idx;
    logic cnt_clr;
    logic cnt_inc;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  evict;
    logic  cnt_last;
    logic  out_free;
  } sts_t;

endpackage

FILE: design/ftar_ctrl.sv
// ----------------------------------------------------------------------------
// ftar_ctrl
// Sequencer of the frame table: dispatch, slot sweep, victim write, result.
// ----------------------------------------------------------------------------
module ftar_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ftar_pkg::sts_t sts,
  output ftar_pkg::cmd_t cmd
);
  import ftar_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (sts.kind)
          K_READ:  state_next = S_READ;
          K_SWEEP: state_next = S_SCAN;
          default: state_next = S_DONE;
        endcase
      end
      S_READ:     state_next = S_DRAIN;
      S_SCAN:     if (sts.cnt_last) state_next = S_DRAIN;
      S_DRAIN:    state_next = sts.evict ? S_FIN : S_DONE;
      S_FIN:      state_next = S_DONE;
      S_DONE:     if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        cmd.cnt_clr  = 1'b1;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        cmd.rd_idx = 1'b1;
      end
      S_SCAN: begin
        cmd.rd      = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_FIN:  cmd.fin = 1'b1;
      S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: design/ftar_dp.sv
// ----------------------------------------------------------------------------
// ftar_dp
// Datapath of the frame table: slot memories, valid bits, sweep and results.
// ----------------------------------------------------------------------------
module ftar_dp #(
  parameter int FRAMES      = ftar_pkg::FRAMES_DEF,
  parameter int RECENT_BITS = ftar_pkg::RECENT_BITS_DEF,
  parameter int PAGE_BITS   = ftar_pkg::PAGE_BITS_DEF,
  parameter int OWNER_BITS  = ftar_pkg::OWNER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ftar_pkg::cmd_t                      cmd,
  output ftar_pkg::sts_t                      sts,
  input  logic [ftar_pkg::OP_W-1:0]           op,
  input  logic [ftar_pkg::IDX_W_IO-1:0]       frame_index,
  input  logic [ftar_pkg::PAGE_W_IO-1:0]      virt_page,
  input  logic [ftar_pkg::OWNER_W_IO-1:0]     owner_id,
  input  logic [ftar_pkg::BITS_W_IO-1:0]      accessed_bits,
  input  logic [ftar_pkg::BITS_W_IO-1:0]      mapped_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ftar_pkg::STATUS_W-1:0]       status,
  output logic                                found,
  output logic [ftar_pkg::IDX_W_IO-1:0]       slot_out,
  output logic [ftar_pkg::PAGE_W_IO-1:0]      page_out,
  output logic [ftar_pkg::OWNER_W_IO-1:0]     owner_out,
  output logic [ftar_pkg::RECENT_W_IO-1:0]    recent_out,
  output logic [ftar_pkg::BITS_W_IO-1:0]      clear_bits,
  output logic [ftar_pkg::OCC_W_IO-1:0]       occupancy
);
  import ftar_pkg::*;

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);
  localparam logic [RECENT_BITS-1:0] REC_MAX = {RECENT_BITS{1'b1}};

  logic [OP_W-1:0]       lat_op;
  logic [IDX_W_IO-1:0]   lat_idx;
  logic [PAGE_BITS-1:0]  lat_page;
  logic [OWNER_BITS-1:0] lat_owner;
  logic [FRAMES-1:0]     lat_acc;
  logic [FRAMES-1:0]     lat_map;

  logic [FRAMES-1:0] valid_vec;
  logic [CNT_W-1:0]  used;
  logic              aging;

  logic [IDX_W-1:0] cnt;
  logic             proc_q;
  logic [IDX_W-1:0] proc_addr;

  logic                   have;
  logic [IDX_W-1:0]       best_addr;
  logic [PAGE_BITS-1:0]   best_page;
  logic [OWNER_BITS-1:0]  best_owner;
  logic [RECENT_BITS-1:0] best_rec;
  logic [IDX_W-1:0]       best_rank;

  logic [STATUS_W-1:0]    res_status;
  logic                   res_found;
  logic [IDX_W_IO-1:0]    res_slot;
  logic [PAGE_W_IO-1:0]   res_page;
  logic [OWNER_W_IO-1:0]  res_owner;
  logic [RECENT_W_IO-1:0] res_recent;
  logic [BITS_W_IO-1:0]   res_clr;

  logic [PAGE_BITS-1:0]   mem_page  [FRAMES];
  logic [OWNER_BITS-1:0]  mem_owner [FRAMES];
  logic [RECENT_BITS-1:0] mem_rec   [FRAMES];
  logic [IDX_W-1:0]       mem_rank  [FRAMES];
  logic [PAGE_BITS-1:0]   rd_page;
  logic [OWNER_BITS-1:0]  rd_owner;
  logic [RECENT_BITS-1:0] rd_rec;
  logic [IDX_W-1:0]       rd_rank;

  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [PAGE_BITS-1:0]   wpage;
  logic [OWNER_BITS-1:0]  wowner;
  logic [RECENT_BITS-1:0] wrec;
  logic [IDX_W-1:0]       wrank;
  logic [IDX_W-1:0]       raddr;

  logic             in_range;
  logic [IDX_W-1:0] idx_n;
  logic             v_idx;
  logic             better;

  assign idx_n    = IDX_W'(lat_idx);
  assign in_range = {1'b0, lat_idx} < (IDX_W_IO + 1)'(FRAMES);
  assign v_idx    = valid_vec[idx_n];
  assign raddr    = cmd.rd_idx ? idx_n : cnt;

  // Operation decode for dispatch, plus the sweep-end and output-free flags.
  always_comb begin
    sts.kind = K_NONE;
    case (lat_op)
      OP_INSERT: sts.kind = in_range ? K_SWEEP : K_NONE;
      OP_REMOVE,
      OP_FIND:   sts.kind = (in_range && v_idx) ? K_READ : K_NONE;
      OP_AGE:    sts.kind = aging ? K_SWEEP : K_NONE;
      OP_EVICT:  sts.kind = (|valid_vec) ? K_SWEEP : K_NONE;
      default:   sts.kind = K_NONE;
    endcase
    sts.evict    = (lat_op == OP_EVICT);
    sts.cnt_last = (cnt == RANK_MAX);
    sts.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lat_op    <= op;
      lat_idx   <= frame_index;
      lat_page  <= PAGE_BITS'(virt_page);
      lat_owner <= OWNER_BITS'(owner_id);
      lat_acc   <= accessed_bits[FRAMES-1:0];
      lat_map   <= mapped_bits[FRAMES-1:0];
    end
  end

  // Table state updated at dispatch.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_vec <= '0;
      used      <= '0;
      aging     <= 1'b0;
    end else if (cmd.dispatch) begin
      case (lat_op)
        OP_INSERT: begin
          if (in_range) begin
            valid_vec[idx_n] <= 1'b1;
            if (!v_idx) used <= used + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (in_range && v_idx) begin
            valid_vec[idx_n] <= 1'b0;
            used <= used - 1'b1;
          end
        end
        OP_EVICT: aging <= 1'b1;
        default: aging <= aging;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      proc_q <= 1'b0;
    end else begin
      proc_q <= cmd.rd;
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc && !sts.cnt_last) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) proc_addr <= raddr;
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_page[waddr]  <= wpage;
      mem_owner[waddr] <= wowner;
      mem_rec[waddr]   <= wrec;
      mem_rank[waddr]  <= wrank;
    end
    if (cmd.rd) begin
      rd_page  <= mem_page[raddr];
      rd_owner <= mem_owner[raddr];
      rd_rec   <= mem_rec[raddr];
      rd_rank  <= mem_rank[raddr];
    end
  end

  always_comb begin
    we     = 1'b0;
    waddr  = proc_addr;
    wpage  = rd_page;
    wowner = rd_owner;
    wrec   = rd_rec;
    wrank  = rd_rank;
    if (proc_q) begin
      case (lat_op)
        OP_INSERT: begin
          if (proc_addr == idx_n) begin
            we     = 1'b1;
            wpage  = lat_page;
            wowner = lat_owner;
            wrec   = '0;
            wrank  = '0;
          end else if (valid_vec[proc_addr] && rd_rank != RANK_MAX) begin
            we    = 1'b1;
            wrank = rd_rank + 1'b1;
          end
        end
        OP_AGE: begin
          if (valid_vec[proc_addr] && lat_map[proc_addr]) begin
            we = 1'b1;
            if (lat_acc[proc_addr]) begin
              wrec = '0;
            end else if (rd_rec != REC_MAX) begin
              wrec = rd_rec + 1'b1;
            end
          end
        end
        default: we = 1'b0;
      endcase
    end
    if (cmd.fin) begin
      we     = 1'b1;
      waddr  = best_addr;
      wpage  = best_page;
      wowner = best_owner;
      wrec   = '0;
      wrank  = best_rank;
    end
  end

  // Larger count wins; on equal counts the smaller rank wins.
  assign better = !have || rd_rec > best_rec || (rd_rec == best_rec && rd_rank < best_rank);

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      have <= 1'b0;
    end else if (proc_q && lat_op == OP_EVICT && valid_vec[proc_addr] && better) begin
      have       <= 1'b1;
      best_addr  <= proc_addr;
      best_page  <= rd_page;
      best_owner <= rd_owner;
      best_rec   <= rd_rec;
      best_rank  <= rd_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      res_status <= ST_OK;
      res_found  <= 1'b0;
      res_slot   <= lat_idx;
      res_page   <= '0;
      res_owner  <= '0;
      res_recent <= '0;
      res_clr    <= '0;
      case (lat_op)
        OP_INSERT: begin
          if (!in_range) begin
            res_status <= ST_MISS;
          end else begin
            res_page  <= PAGE_W_IO'(lat_page);
            res_owner <= OWNER_W_IO'(lat_owner);
          end
        end
        OP_REMOVE,
        OP_FIND: begin
          if (!in_range || !v_idx) begin
            res_status <= ST_MISS;
          end else begin
            res_found <= 1'b1;
          end
        end
        OP_AGE: begin
          if (aging) res_clr <= BITS_W_IO'(lat_acc & lat_map & valid_vec);
        end
        OP_EVICT: begin
          if (valid_vec == '0) begin
            res_status <= ST_EMPTY;
            res_slot   <= '0;
          end
        end
        default: res_status <= ST_OK;
      endcase
    end else if (proc_q && (lat_op == OP_REMOVE || lat_op == OP_FIND)) begin
      res_page   <= PAGE_W_IO'(rd_page);
      res_owner  <= OWNER_W_IO'(rd_owner);
      res_recent <= RECENT_W_IO'(rd_rec);
    end else if (cmd.fin) begin
      res_slot   <= IDX_W_IO'(best_addr);
      res_page   <= PAGE_W_IO'(best_page);
      res_owner  <= OWNER_W_IO'(best_owner);
      res_recent <= RECENT_W_IO'(best_rec);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_status;
      found      <= res_found;
      slot_out   <= res_slot;
      page_out   <= res_page;
      owner_out  <= res_owner;
      recent_out <= res_recent;
      clear_bits <= res_clr;
      occupancy  <= OCC_W_IO'(used);
    end
  end

endmodule

FILE: design/frame_table_aging_replacement_top.sv
// ----------------------------------------------------------------------------
// frame_table_aging_replacement_top
// Frame table with aging replacement: insert, remove, find, age tick and
// victim choice over a table of FRAMES slots.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------
//   input   | in_valid / in_ready  | op, frame_index, virt_page, owner_id,
//           |                      | accessed_bits, mapped_bits
//   result  | out_valid / out_ready| status, found, slot_out, page_out,
//           |                      | owner_out, recent_out, clear_bits,
//           |                      | occupancy
//
// One item is worked at a time. Insert, age tick once aging is on, and
// victim choice on a non-empty table sweep the slot memories, which have
// one read and one write port; victim choice then writes its victim back.
// A find or remove of a present frame reads one slot; all else skips both.
// Reset is synchronous: it clears the valid bits, the occupancy count and the
// aging enable; the slot memories need no clearing since only the contents
// of valid slots are used. The result sits in an output register, so a new
// item is taken while a result is still waiting; the block then stalls
// before its own result until that register frees up.

module frame_table_aging_replacement_top #(
  parameter int FRAMES      = ftar_pkg::FRAMES_DEF,
  parameter int RECENT_BITS = ftar_pkg::RECENT_BITS_DEF,
  parameter int PAGE_BITS   = ftar_pkg::PAGE_BITS_DEF,
  parameter int OWNER_BITS  = ftar_pkg::OWNER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ftar_pkg::OP_W-1:0]           op,
  input  logic [ftar_pkg::IDX_W_IO-1:0]       frame_index,
  input  logic [ftar_pkg::PAGE_W_IO-1:0]      virt_page,
  input  logic [ftar_pkg::OWNER_W_IO-1:0]     owner_id,
  input  logic [ftar_pkg::BITS_W_IO-1:0]      accessed_bits,
  input  logic [ftar_pkg::BITS_W_IO-1:0]      mapped_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ftar_pkg::STATUS_W-1:0]       status,
  output logic                                found,
  output logic [ftar_pkg::IDX_W_IO-1:0]       slot_out,
  output logic [ftar_pkg::PAGE_W_IO-1:0]      page_out,
  output logic [ftar_pkg::OWNER_W_IO-1:0]     owner_out,
  output logic [ftar_pkg::RECENT_W_IO-1:0]    recent_out,
  output logic [ftar_pkg::BITS_W_IO-1:0]      clear_bits,
  output logic [ftar_pkg::OCC_W_IO-1:0]       occupancy
);
  import ftar_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The sequencer owns the input handshake and steps the datapath through
  // dispatch, the slot sweep, the victim write-back and the result load.
  ftar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table, decodes the operation and drives the
  // result register.
  ftar_dp #(
    .FRAMES      (FRAMES),
    .RECENT_BITS (RECENT_BITS),
    .PAGE_BITS   (PAGE_BITS),
    .OWNER_BITS  (OWNER_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .frame_index   (frame_index),
    .virt_page     (virt_page),
    .owner_id      (owner_id),
    .accessed_bits (accessed_bits),
    .mapped_bits   (mapped_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found         (found),
    .slot_out      (slot_out),
    .page_out      (page_out),
    .owner_out     (owner_out),
    .recent_out    (recent_out),
    .clear_bits    (clear_bits),
    .occupancy     (occupancy)
  );

endmodule

FILE: design/ftar_checker.sv
// ----------------------------------------------------------------------------
// ftar_checker
// Port-level checks of the frame table, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_table_aging_replacement_top_assert.svh"

module ftar_checker #(
  parameter int FRAMES = ftar_pkg::FRAMES_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ftar_pkg::STATUS_W-1:0] status,
  input logic                          found,
  input logic [ftar_pkg::OCC_W_IO-1:0] occupancy
);
  import ftar_pkg::*;

  `FTAR_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `FTAR_ASSERT(a_result_holds, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(occupancy)))
  `FTAR_NEVER(a_occ_bound, clk, rst, out_valid && occupancy > OCC_W_IO'(FRAMES))
  `FTAR_NEVER(a_found_ok, clk, rst, out_valid && found && status != ST_OK)
  `FTAR_NEVER(a_empty_occ, clk, rst, out_valid && status == ST_EMPTY && occupancy != '0)

endmodule

bind frame_table_aging_replacement_top ftar_checker #(.FRAMES(FRAMES)) u_ftar_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .found     (found),
  .occupancy (occupancy)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame table aging replacement testbench
// Drives insert, remove, find, age tick and victim choice items into the
// frame table with random gaps and output stalls. A scoreboard class keeps
// its own copy of the table, predicts every result and compares each field.
// ----------------------------------------------------------------------------

class frame_table_scoreboard;
  bit              valid_q [64];
  bit [19:0]       page_q [64];
  bit [7:0]        owner_q [64];
  bit [7:0]        recent_q [64];
  bit [5:0]        rank_q [64];
  bit              aging_on;
  bit [6:0]        used;
  bit [1:0]        st_q [$];
  bit              fd_q [$];
  bit [5:0]        sl_q [$];
  bit [19:0]       pg_q [$];
  bit [7:0]        ow_q [$];
  bit [7:0]        rc_q [$];
  bit [63:0]       cl_q [$];
  bit [6:0]        oc_q [$];
  int              errors;
  int              checked;
  int              victims;
  int              ages;

  function void push_result(bit [1:0] st, bit fd, bit [5:0] sl, bit [19:0] pg,
                            bit [7:0] ow, bit [7:0] rc, bit [63:0] cl);
    st_q.push_back(st); fd_q.push_back(fd); sl_q.push_back(sl);
    pg_q.push_back(pg); ow_q.push_back(ow); rc_q.push_back(rc);
    cl_q.push_back(cl); oc_q.push_back(used);
  endfunction

  // Update the table for one accepted item and queue the result it causes.
  function void note_item(bit [2:0] op, bit [5:0] idx, bit [19:0] vp, bit [7:0] own,
                          bit [63:0] acc, bit [63:0] mapd);
    bit [63:0] clr;
    int        best;
    bit [7:0]  rec;
    clr = '0;
    best = -1;
    if (op == ftar_pkg::OP_INSERT) begin
      for (int i = 0; i < 64; i++)
        if (i != idx && valid_q[i] && rank_q[i] < 63) rank_q[i]++;
      if (!valid_q[idx]) used++;
      valid_q[idx] = 1; page_q[idx] = vp; owner_q[idx] = own;
      recent_q[idx] = 0; rank_q[idx] = 0;
      push_result(ftar_pkg::ST_OK, 0, idx, vp, own, 0, 0);
    end else if (op == ftar_pkg::OP_REMOVE || op == ftar_pkg::OP_FIND) begin
      if (!valid_q[idx]) begin
        push_result(ftar_pkg::ST_MISS, 0, idx, 0, 0, 0, 0);
      end else begin
        if (op == ftar_pkg::OP_REMOVE) begin
          valid_q[idx] = 0;
          used--;
        end
        push_result(ftar_pkg::ST_OK, 1, idx, page_q[idx], owner_q[idx], recent_q[idx], 0);
      end
    end else if (op == ftar_pkg::OP_AGE) begin
      ages++;
      if (aging_on)
        for (int i = 0; i < 64; i++) begin
          if (!valid_q[i] || !mapd[i]) continue;
          if (acc[i]) begin
            recent_q[i] = 0;
            clr[i] = 1;
          end else if (recent_q[i] != 8'hFF) begin
            recent_q[i]++;
          end
        end
      push_result(ftar_pkg::ST_OK, 0, idx, 0, 0, 0, clr);
    end else if (op == ftar_pkg::OP_EVICT) begin
      aging_on = 1;
      for (int i = 0; i < 64; i++) begin
        if (!valid_q[i]) continue;
        if (best < 0 || recent_q[i] > recent_q[best] ||
            (recent_q[i] == recent_q[best] && rank_q[i] < rank_q[best]))
          best = i;
      end
      if (best < 0) begin
        push_result(ftar_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0);
      end else begin
        victims++;
        rec = recent_q[best];
        recent_q[best] = 0;
        push_result(ftar_pkg::ST_OK, 0, 6'(best), page_q[best], owner_q[best], rec, 0);
      end
    end else begin
      push_result(ftar_pkg::ST_OK, 0, idx, 0, 0, 0, 0);
    end
  endfunction

  function void cmp(string name, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(bit [1:0] st, bit fd, bit [5:0] sl, bit [19:0] pg,
                             bit [7:0] ow, bit [7:0] rc, bit [63:0] cl, bit [6:0] oc);
    if (st_q.size() == 0) begin
      $error("result transfer with no expected result waiting");
      errors++;
      return;
    end
    checked++;
    cmp("status", st_q.pop_front(), st);
    cmp("found", fd_q.pop_front(), fd);
    cmp("slot_out", sl_q.pop_front(), sl);
    cmp("page_out", pg_q.pop_front(), pg);
    cmp("owner_out", ow_q.pop_front(), ow);
    cmp("recent_out", rc_q.pop_front(), rc);
    cmp("clear_bits", cl_q.pop_front(), cl);
    cmp("occupancy", oc_q.pop_front(), oc);
  endfunction

  function int pending();
    return st_q.size();
  endfunction
endclass

module testbench;
  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  op = '0;
  logic [5:0]  frame_index = '0;
  logic [19:0] virt_page = '0;
  logic [7:0]  owner_id = '0;
  logic [63:0] accessed_bits = '0;
  logic [63:0] mapped_bits = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic        found;
  logic [5:0]  slot_out;
  logic [19:0] page_out;
  logic [7:0]  owner_out;
  logic [7:0]  recent_out;
  logic [63:0] clear_bits;
  logic [6:0]  occupancy;

  frame_table_scoreboard table_model = new();
  int  cycle_count = 0;
  bit  calm_phase = 0;   // no idling on either side while set
  bit  hold_off = 0;     // the receiver refuses results while set
  int  fill_level = 0;   // rough number of valid slots the stimulus aims for

  localparam int CYCLE_LIMIT = 2000000;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  frame_table_aging_replacement_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .frame_index(frame_index), .virt_page(virt_page), .owner_id(owner_id),
    .accessed_bits(accessed_bits), .mapped_bits(mapped_bits), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .found(found), .slot_out(slot_out),
    .page_out(page_out), .owner_out(owner_out), .recent_out(recent_out),
    .clear_bits(clear_bits), .occupancy(occupancy)
  );

  // The receiver stalls at random about 11 percent of the time, never during the calm
  // phase, and throughout the long hold-off. Results are checked at the
  // edge on which the transfer happens, before any input changes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL frame_table_aging_replacement_top");
      $finish;
    end
    if (!rst && out_valid && out_ready)
      table_model.check_result(status, found, slot_out, page_out, owner_out, recent_out,
                               clear_bits, occupancy);
    if (rst || hold_off)
      out_ready <= 0;
    else
      out_ready <= calm_phase || ($urandom_range(99) >= 11);
  end

  // Offer one item and wait for its transfer. The item is noted in the
  // scoreboard at the accepting edge, so expected results stay in order.
  // Valid drops only while idling, so back-to-back items keep it high and
  // the caller lowers it once the last item has gone.
  task automatic send_item(bit [2:0] o, bit [5:0] idx, bit [19:0] vp, bit [7:0] own,
                           bit [63:0] acc, bit [63:0] mapd);
    while (!calm_phase && $urandom_range(99) < 11) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    op <= o; frame_index <= idx; virt_page <= vp; owner_id <= own;
    accessed_bits <= acc; mapped_bits <= mapd;
    do @(posedge clk); while (!in_ready);
    table_model.note_item(o, idx, vp, own, acc, mapd);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random item biased toward useful work: inserts keep the table partly full,
  // finds and removes mostly hit, and age ticks and victim choices recur often.
  task automatic send_random();
    int        pick;
    bit [2:0]  o;
    bit [5:0]  idx;
    bit [63:0] acc;
    bit [63:0] mapd;
    pick = $urandom_range(99);
    idx = 6'($urandom_range(fill_level));
    acc = rand64();
    mapd = rand64();
    if ($urandom_range(3) == 0) acc = acc & rand64();
    if ($urandom_range(3) == 0) mapd = '1;
    if ($urandom_range(7) == 0) acc = '0;
    if (pick < 30) o = ftar_pkg::OP_INSERT;
    else if (pick < 42) o = ftar_pkg::OP_REMOVE;
    else if (pick < 56) o = ftar_pkg::OP_FIND;
    else if (pick < 78) o = ftar_pkg::OP_AGE;
    else if (pick < 96) o = ftar_pkg::OP_EVICT;
    else o = 3'($urandom_range(7, 5));
    send_item(o, idx, 20'($urandom()), 8'($urandom()), acc, mapd);
  endtask

  initial begin
    int full_errors;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: empty table cases, age tick before any victim choice,
    // extremes of each field, replacement, misses and unused op codes.
    calm_phase = 1;
    send_item(ftar_pkg::OP_FIND, 6'd0, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_REMOVE, 6'd63, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_AGE, 6'd5, '0, '0, '1, '1);
    send_item(ftar_pkg::OP_INSERT, 6'd0, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_AGE, 6'd0, '0, '0, '0, '1);
    send_item(ftar_pkg::OP_INSERT, 6'd63, '1, '1, '1, '1);
    send_item(ftar_pkg::OP_INSERT, 6'd31, 20'h5A5A5, 8'hA5, '0, '0);
    send_item(ftar_pkg::OP_FIND, 6'd63, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_EVICT, 6'd0, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_AGE, 6'd0, '0, '0, 64'h8000_0000_0000_0000, '1);
    send_item(ftar_pkg::OP_AGE, 6'd0, '0, '0, '0, 64'h0000_0000_8000_0001);
    send_item(ftar_pkg::OP_EVICT, 6'd0, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_INSERT, 6'd31, 20'hFFFFF, 8'h00, '0, '0);
    send_item(ftar_pkg::OP_REMOVE, 6'd31, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_REMOVE, 6'd31, '0, '0, '0, '0);
    send_item(3'd5, 6'd17, '1, '1, '1, '1);
    send_item(3'd7, 6'd63, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_REMOVE, 6'd0, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_REMOVE, 6'd63, '0, '0, '0, '0);
    send_item(ftar_pkg::OP_EVICT, 6'd9, '0, '0, '0, '0);
    calm_phase = 0;

    // Fill the whole table, then saturate every count with 300 idle ticks so
    // that victim ties fall back to rank.
    for (int i = 0; i < 64; i++)
      send_item(ftar_pkg::OP_INSERT, 6'(i), 20'($urandom()), 8'($urandom()), '0, '0);
    send_item(ftar_pkg::OP_EVICT, 6'd0, '0, '0, '0, '0);
    for (int i = 0; i < 300; i++)
      send_item(ftar_pkg::OP_AGE, 6'($urandom()), '0, '0, '0, '1);
    for (int i = 0; i < 6; i++)
      send_item(ftar_pkg::OP_EVICT, 6'($urandom()), '0, '0, '0, '0);

    // Long receiver hold-off while the sender keeps offering items, so the
    // block fills its output register and stalls its input.
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_random();
    join

    // Random phases over varying fill targets, one of them without idling.
    for (int phase = 0; phase < 10; phase++) begin
      fill_level = (phase % 3 == 0) ? 63 : $urandom_range(3, 20);
      calm_phase = (phase == 4);
      for (int i = 0; i < 90; i++) send_random();
    end
    calm_phase = 0;
    in_valid <= 0;

    while (table_model.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    full_errors = table_model.errors;
    $display("checked %0d results: %0d victim choices with a hit, %0d age ticks",
             table_model.checked, table_model.victims, table_model.ages);
    if (full_errors == 0)
      $display("PASS frame_table_aging_replacement_top");
    else
      $display("FAIL frame_table_aging_replacement_top");
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/ftar_pkg.sv
design/ftar_ctrl.sv
design/ftar_dp.sv
design/frame_table_aging_replacement_top.sv
design/ftar_checker.sv
tb/sv/testbench.sv
